// ===== src/wsd_pkg.sv =====
`default_nettype none
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_RIFF      = 3'd0,
    PH_JUNK_SIZE = 3'd1,
    PH_JUNK_SKIP = 3'd2,
    PH_JUNK_ID   = 3'd3,
    PH_FMT       = 3'd4,
    PH_DATA      = 3'd5,
    PH_IDLE      = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_FORMAT  = 3'd1,
    ERR_ALIGN   = 3'd2,
    ERR_NO_CHAN = 3'd3,
    ERR_OVERRUN = 3'd4
  } err_t;

  localparam logic [31:0] JUNK_WORD = 32'h4B4E554A;
  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic [5:0] OFS_RIFF_END = 6'd15;
  localparam logic [5:0] OFS_WORD_END = 6'd3;
  localparam logic [5:0] OFS_FORMAT   = 6'd5;
  localparam logic [5:0] OFS_CHANNELS = 6'd7;
  localparam logic [5:0] OFS_RATE     = 6'd11;
  localparam logic [5:0] OFS_ALIGN    = 6'd17;
  localparam logic [5:0] OFS_WIDTH    = 6'd19;
  localparam logic [5:0] OFS_FMT_END  = 6'd27;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] raw;
    logic [15:0] channel;
    logic        frame_last;
    logic        data_last;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_width;
    logic [15:0] frame_bytes;
    logic [2:0]  error_code;
  } item_t;

endpackage
`default_nettype wire

// ===== src/wsd_byte_if.sv =====
`default_nettype none
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface
`default_nettype wire

// ===== src/wsd_result_if.sv =====
`default_nettype none
interface wsd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] sample_bits;
  logic [15:0] channel;
  logic        frame_last;
  logic        data_last;
  logic [15:0] format_code;
  logic [15:0] channel_count;
  logic [31:0] rate_hz;
  logic [15:0] sample_width;
  logic [15:0] frame_bytes;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output sample_bits, output channel,
                  output frame_last, output data_last, output format_code,
                  output channel_count, output rate_hz, output sample_width,
                  output frame_bytes, output error_code, input ready);
  modport sink (input valid, input kind, input sample_bits, input channel,
                input frame_last, input data_last, input format_code,
                input channel_count, input rate_hz, input sample_width,
                input frame_bytes, input error_code, output ready);
endinterface
`default_nettype wire

// ===== src/wav_stream_sample_decoder.sv =====
// Channel | Direction | Beat
// wav     | in        | one file byte, start_of_file marks byte 0 of a file
// res     | out       | one header, sample or error item
//
// One byte is taken per cycle while wav.ready is high; the parser decides everything
// for a byte in that cycle. A result reaches the output through an item register, then
// the float conversion into the output register.
// Reset (rst, synchronous) puts the parser at header byte 0 and empties both registers.
// A stalled output stops the byte input only once both registers are full.
`default_nettype none
module wav_stream_sample_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  wsd_byte_if.sink    wav,
  wsd_result_if.source res
);

  wsd_pkg::phase_t phase, c_phase, n_phase;
  logic [5:0]  hoff, c_hoff, n_hoff;
  logic [31:0] fshift, c_fshift, n_fshift;
  logic [31:0] junk_left, c_junk, n_junk;
  logic [15:0] s_fmt, c_fmt, n_fmt;
  logic [15:0] s_ch, c_ch, n_ch;
  logic [31:0] s_rate, c_rate, n_rate;
  logic [15:0] s_align, c_align, n_align;
  logic [15:0] s_width, c_width, n_width;
  logic [31:0] bytes_left, c_bleft, n_bleft;
  logic [15:0] frame_pos, c_fpos, n_fpos;
  logic [15:0] ch_pos, c_chpos, n_chpos;
  logic [63:0] asm_word, c_asm, n_asm;
  logic [2:0]  sb_pos, c_sbpos, n_sbpos;
  logic        last_flag, c_last, n_last;
  logic [15:0] span, c_span, n_span;

  logic        em;
  wsd_pkg::item_t em_item;
  logic        s1_valid;
  wsd_pkg::item_t s1;
  logic        advance;
  logic        take;

  logic        ok;
  logic [28:0] prod;
  logic [3:0]  bps;
  logic [16:0] fpos_inc;
  logic [16:0] chpos_inc;
  logic        fl;
  logic [31:0] bl_sub;
  logic [2:0]  errc;

  assign advance = !res.valid || res.ready;
  assign wav.ready = !s1_valid || advance;
  assign take = wav.valid && wav.ready;

  function automatic logic [31:0] pcm_to_f32(input logic [23:0] v, input logic wide);
    logic [23:0] mag;
    logic [4:0]  p;
    logic [23:0] norm;
    logic [7:0]  ex;
    logic        any;
    mag = v[23] ? (~v + 24'd1) : v;
    p = 5'd0;
    any = 1'b0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) begin
        p = 5'(i);
        any = 1'b1;
      end
    end
    norm = mag << (5'd23 - p);
    ex = 8'd127 + {3'd0, p} - (wide ? 8'd23 : 8'd15);
    pcm_to_f32 = any ? {v[23], ex, norm[22:0]} : 32'h0;
  endfunction

  function automatic logic [31:0] dbl_to_single(input logic [63:0] b);
    logic [31:0] sgn;
    logic [10:0] e;
    logic [51:0] m;
    logic signed [12:0] ef;
    logic signed [12:0] shift;
    logic [5:0]  sh;
    logic [52:0] full;
    logic [52:0] q;
    logic [52:0] mask;
    logic [52:0] rem;
    logic [52:0] half;
    logic [7:0]  ebias;
    sgn = {b[63], 31'd0};
    e = b[62:52];
    m = b[51:0];
    ef = $signed({2'b00, e}) - 13'sd896;
    shift = (ef >= 13'sd1) ? 13'sd29 : (13'sd30 - ef);
    sh = shift[5:0];
    full = {1'b1, m};
    q = full >> sh;
    mask = (53'd1 << sh) - 53'd1;
    rem = full & mask;
    half = 53'd1 << (sh - 6'd1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 53'd1;
    end
    ebias = 8'(ef - 13'sd1);
    if (e == 11'h7FF) begin
      dbl_to_single = (m == 52'd0) ? (sgn | 32'h7F800000)
                                   : (sgn | 32'h7FC00000 | {9'd0, m[51:29]});
    end else if (e == 11'd0) begin
      dbl_to_single = sgn;
    end else if (ef >= 13'sd255) begin
      dbl_to_single = sgn | 32'h7F800000;
    end else if (shift >= 13'sd54) begin
      dbl_to_single = sgn;
    end else if (ef >= 13'sd1) begin
      dbl_to_single = sgn | ({1'b0, ebias, 23'd0} + q[31:0]);
    end else begin
      dbl_to_single = sgn | q[31:0];
    end
  endfunction

  always_comb begin
    if (wav.start_of_file) begin
      c_phase = wsd_pkg::PH_RIFF;
      c_hoff = '0; c_fshift = '0; c_junk = '0; c_fmt = '0; c_ch = '0;
      c_rate = '0; c_align = '0; c_width = '0; c_bleft = '0; c_fpos = '0;
      c_chpos = '0; c_asm = '0; c_sbpos = '0; c_last = 1'b0; c_span = '0;
    end else begin
      c_phase = phase;
      c_hoff = hoff; c_fshift = fshift; c_junk = junk_left; c_fmt = s_fmt;
      c_ch = s_ch; c_rate = s_rate; c_align = s_align; c_width = s_width;
      c_bleft = bytes_left; c_fpos = frame_pos; c_chpos = ch_pos; c_asm = asm_word;
      c_sbpos = sb_pos; c_last = last_flag; c_span = span;
    end
    n_phase = c_phase; n_hoff = c_hoff; n_junk = c_junk; n_fmt = c_fmt;
    n_ch = c_ch; n_rate = c_rate; n_align = c_align; n_width = c_width;
    n_bleft = c_bleft; n_fpos = c_fpos; n_chpos = c_chpos; n_asm = c_asm;
    n_sbpos = c_sbpos; n_last = c_last; n_span = c_span;
    n_fshift = c_fshift;
    if (c_phase == wsd_pkg::PH_RIFF || c_phase == wsd_pkg::PH_JUNK_SIZE ||
        c_phase == wsd_pkg::PH_JUNK_ID || c_phase == wsd_pkg::PH_FMT) begin
      n_fshift = {wav.data_byte, c_fshift[31:8]};
    end

    ok = (c_fmt == wsd_pkg::FMT_PCM && (c_width == 16'd16 || c_width == 16'd24)) ||
         (c_fmt == wsd_pkg::FMT_FLOAT && (c_width == 16'd32 || c_width == 16'd64));
    prod = 29'(c_ch) * 29'(c_width[15:3]);
    bps = c_width[6:3];
    fpos_inc = {1'b0, c_fpos} + 17'd1;
    chpos_inc = {1'b0, c_chpos} + 17'd1;
    fl = (chpos_inc == {1'b0, c_ch});
    bl_sub = c_bleft - {16'd0, c_align};
    errc = wsd_pkg::ERR_NONE;

    em = 1'b0;
    em_item.kind = wsd_pkg::KIND_HEADER;
    em_item.raw = '0;
    em_item.channel = '0;
    em_item.frame_last = 1'b0;
    em_item.data_last = 1'b0;
    em_item.format_code = c_fmt;
    em_item.channel_count = c_ch;
    em_item.rate_hz = c_rate;
    em_item.sample_width = c_width;
    em_item.frame_bytes = c_align;
    em_item.error_code = wsd_pkg::ERR_NONE;

    case (c_phase)
      wsd_pkg::PH_RIFF: begin
        if (c_hoff == wsd_pkg::OFS_RIFF_END) begin
          n_hoff = '0;
          n_phase = (n_fshift == wsd_pkg::JUNK_WORD) ? wsd_pkg::PH_JUNK_SIZE
                                                     : wsd_pkg::PH_FMT;
        end else begin
          n_hoff = c_hoff + 6'd1;
        end
      end
      wsd_pkg::PH_JUNK_SIZE: begin
        if (c_hoff == wsd_pkg::OFS_WORD_END) begin
          n_hoff = '0;
          n_junk = n_fshift;
          n_phase = (n_fshift != 32'd0) ? wsd_pkg::PH_JUNK_SKIP : wsd_pkg::PH_JUNK_ID;
        end else begin
          n_hoff = c_hoff + 6'd1;
        end
      end
      wsd_pkg::PH_JUNK_SKIP: begin
        n_junk = c_junk - 32'd1;
        if (n_junk == 32'd0) begin
          n_phase = wsd_pkg::PH_JUNK_ID;
        end
      end
      wsd_pkg::PH_JUNK_ID: begin
        if (c_hoff == wsd_pkg::OFS_WORD_END) begin
          n_hoff = '0;
          n_phase = wsd_pkg::PH_FMT;
        end else begin
          n_hoff = c_hoff + 6'd1;
        end
      end
      wsd_pkg::PH_FMT: begin
        if (c_hoff == wsd_pkg::OFS_FORMAT) n_fmt = n_fshift[31:16];
        if (c_hoff == wsd_pkg::OFS_CHANNELS) n_ch = n_fshift[31:16];
        if (c_hoff == wsd_pkg::OFS_RATE) n_rate = n_fshift;
        if (c_hoff == wsd_pkg::OFS_ALIGN) n_align = n_fshift[31:16];
        if (c_hoff == wsd_pkg::OFS_WIDTH) n_width = n_fshift[31:16];
        if (c_hoff == wsd_pkg::OFS_FMT_END) begin
          n_hoff = '0;
          em = 1'b1;
          if (!ok) errc = wsd_pkg::ERR_FORMAT;
          else if (c_align == 16'd0) errc = wsd_pkg::ERR_ALIGN;
          else if (c_ch == 16'd0) errc = wsd_pkg::ERR_NO_CHAN;
          else if (prod > {13'd0, c_align}) errc = wsd_pkg::ERR_OVERRUN;
          if (errc != wsd_pkg::ERR_NONE) begin
            n_phase = wsd_pkg::PH_IDLE;
            em_item.kind = wsd_pkg::KIND_ERROR;
            em_item.error_code = errc;
          end else begin
            n_bleft = n_fshift;
            n_fpos = '0;
            n_chpos = '0;
            n_sbpos = '0;
            n_asm = '0;
            n_span = prod[15:0];
            n_last = ({1'b0, n_fshift} < {16'd0, c_align, 1'b0});
            n_phase = (n_fshift < {16'd0, c_align}) ? wsd_pkg::PH_IDLE
                                                     : wsd_pkg::PH_DATA;
            em_item.data_last = (n_fshift < {16'd0, c_align});
          end
        end else begin
          n_hoff = c_hoff + 6'd1;
        end
      end
      wsd_pkg::PH_DATA: begin
        if (c_fpos < c_span) begin
          n_asm = (c_sbpos == 3'd0) ? 64'd0 : c_asm;
          n_asm[{c_sbpos, 3'b000} +: 8] = wav.data_byte;
          if ({1'b0, c_sbpos} + 4'd1 >= bps) begin
            em = 1'b1;
            em_item.kind = wsd_pkg::KIND_SAMPLE;
            em_item.raw = n_asm;
            em_item.channel = c_chpos;
            em_item.frame_last = fl;
            em_item.data_last = fl && c_last;
            n_chpos = chpos_inc[15:0];
            n_sbpos = '0;
          end else begin
            n_sbpos = c_sbpos + 3'd1;
          end
        end
        n_fpos = fpos_inc[15:0];
        if (fpos_inc >= {1'b0, c_align}) begin
          n_fpos = '0;
          n_chpos = '0;
          n_sbpos = '0;
          n_bleft = bl_sub;
          n_last = ({1'b0, bl_sub} < {16'd0, c_align, 1'b0});
          if (bl_sub < {16'd0, c_align}) begin
            n_phase = wsd_pkg::PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wsd_pkg::PH_RIFF;
      hoff <= '0; fshift <= '0; junk_left <= '0; s_fmt <= '0; s_ch <= '0;
      s_rate <= '0; s_align <= '0; s_width <= '0; bytes_left <= '0;
      frame_pos <= '0; ch_pos <= '0; asm_word <= '0; sb_pos <= '0;
      last_flag <= 1'b0; span <= '0;
    end else if (take) begin
      phase <= n_phase;
      hoff <= n_hoff; fshift <= n_fshift; junk_left <= n_junk; s_fmt <= n_fmt;
      s_ch <= n_ch; s_rate <= n_rate; s_align <= n_align; s_width <= n_width;
      bytes_left <= n_bleft; frame_pos <= n_fpos; ch_pos <= n_chpos;
      asm_word <= n_asm; sb_pos <= n_sbpos; last_flag <= n_last; span <= n_span;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (wav.ready) begin
      s1_valid <= take && em;
    end
  end

  always_ff @(posedge clk) begin
    if (take && em) begin
      s1 <= em_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res.kind <= s1.kind;
      res.channel <= s1.channel;
      res.frame_last <= s1.frame_last;
      res.data_last <= s1.data_last;
      res.format_code <= s1.format_code;
      res.channel_count <= s1.channel_count;
      res.rate_hz <= s1.rate_hz;
      res.sample_width <= s1.sample_width;
      res.frame_bytes <= s1.frame_bytes;
      res.error_code <= s1.error_code;
      if (s1.kind != wsd_pkg::KIND_SAMPLE) begin
        res.sample_bits <= 32'd0;
      end else if (s1.sample_width == 16'd16) begin
        res.sample_bits <= pcm_to_f32({{8{s1.raw[15]}}, s1.raw[15:0]}, 1'b0);
      end else if (s1.sample_width == 16'd24) begin
        res.sample_bits <= pcm_to_f32(s1.raw[23:0], 1'b1);
      end else if (s1.sample_width == 16'd32) begin
        res.sample_bits <= s1.raw[31:0];
      end else begin
        res.sample_bits <= dbl_to_single(s1.raw);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/wsd_checker.sv =====
`default_nettype none
module wsd_assertions (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [31:0] sample_bits,
  input wire logic [15:0] channel,
  input wire logic        frame_last,
  input wire logic        data_last,
  input wire logic [2:0]  error_code
);

  // A result beat waits until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(sample_bits))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == wsd_pkg::KIND_ERROR) == (error_code != wsd_pkg::ERR_NONE)))
    else $error("error code disagrees with item kind");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != wsd_pkg::KIND_SAMPLE |->
      sample_bits == 32'd0 && channel == 16'd0 && !frame_last)
    else $error("non-sample item carries sample fields");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == wsd_pkg::KIND_SAMPLE && data_last |-> frame_last)
    else $error("final sample is not the end of a frame");

endmodule

bind wav_stream_sample_decoder wsd_assertions u_wsd_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .kind(res.kind),
  .sample_bits(res.sample_bits),
  .channel(res.channel),
  .frame_last(res.frame_last),
  .data_last(res.data_last),
  .error_code(res.error_code)
);
`default_nettype wire

// ===== test/wsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsd_checker (
  input  wire logic clk,
  input  wire logic rst,
  wsd_byte_if       wav,
  wsd_result_if     res,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    wsd_pkg::kind_t kind;
    logic [31:0]    bits;
    logic [15:0]    chan;
    logic           fl;
    logic           dl;
    logic [15:0]    fmt;
    logic [15:0]    nch;
    logic [31:0]    rate;
    logic [15:0]    width;
    logic [15:0]    align;
    wsd_pkg::err_t  err;
  } decoded_t;

  decoded_t    decoded_q[$];

  wsd_pkg::phase_t pstate;
  logic [5:0]  hdr_ofs;
  logic [31:0] acc_word;
  logic [31:0] skip_left;
  logic [15:0] fmt_tag;
  logic [15:0] n_chan;
  logic [31:0] rate;
  logic [15:0] align;
  logic [15:0] bits_per;
  logic [31:0] frames_left;
  logic [15:0] byte_in_frame;
  logic [15:0] chan_idx;
  logic [63:0] sample_word;
  logic [2:0]  byte_in_sample;
  logic        on_last_frame;

  assign pending = decoded_q.size();

  function automatic void clear_parser();
    pstate = wsd_pkg::PH_RIFF;
    hdr_ofs = '0;
    acc_word = '0;
    skip_left = '0;
    fmt_tag = '0;
    n_chan = '0;
    rate = '0;
    align = '0;
    bits_per = '0;
    frames_left = '0;
    byte_in_frame = '0;
    chan_idx = '0;
    sample_word = '0;
    byte_in_sample = '0;
    on_last_frame = 1'b0;
  endfunction

  function automatic void push_item(wsd_pkg::kind_t k, logic [31:0] b, logic [15:0] c,
                                    logic fl, logic dl, wsd_pkg::err_t e);
    decoded_t d;
    d.kind = k;
    d.bits = b;
    d.chan = c;
    d.fl = fl;
    d.dl = dl;
    d.fmt = fmt_tag;
    d.nch = n_chan;
    d.rate = rate;
    d.width = bits_per;
    d.align = align;
    d.err = e;
    decoded_q.push_back(d);
  endfunction

  // Exact for PCM: every 16 and 24 bit integer fits in the float32 mantissa.
  function automatic logic [31:0] pcm_to_f32(int v, int frac);
    logic [31:0] mag;
    int          msb;
    logic [31:0] man;
    mag = (v < 0) ? -v : v;
    if (mag == 0) return 32'h0;
    msb = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
    man = (mag << (23 - msb)) & 32'h7FFFFF;
    return {v < 0, 8'(msb - frac + 127), man[22:0]};
  endfunction

  function automatic logic [31:0] dbl_to_single(logic [63:0] b);
    logic [31:0] sgn;
    int          e;
    int          ef;
    int          sh;
    logic [63:0] m;
    logic [63:0] full;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    sgn = {b[63], 31'h0};
    e = b[62:52];
    m = {12'h0, b[51:0]};
    if (e == 'h7FF) begin
      if (m == 0) return sgn | 32'h7F800000;
      return sgn | 32'h7FC00000 | 32'(m >> 29);
    end
    if (e == 0) return sgn;
    ef = e - 896;
    if (ef >= 255) return sgn | 32'h7F800000;
    sh = (ef >= 1) ? 29 : 30 - ef;
    if (sh >= 54) return sgn;
    full = m | (64'h1 << 52);
    q = full >> sh;
    rem = full & ((64'h1 << sh) - 1);
    half = 64'h1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (ef >= 1) return sgn | 32'((64'(ef - 1) << 23) + q);
    return sgn | 32'(q);
  endfunction

  function automatic logic [31:0] to_f32(logic [63:0] a);
    case (bits_per)
      16'd16:  return pcm_to_f32($signed(a[15:0]), 15);
      16'd24:  return pcm_to_f32($signed(a[23:0]), 23);
      16'd32:  return a[31:0];
      default: return dbl_to_single(a);
    endcase
  endfunction

  function automatic void close_header();
    wsd_pkg::err_t e;
    bit            ok;
    ok = (fmt_tag == wsd_pkg::FMT_PCM && (bits_per == 16 || bits_per == 24)) ||
         (fmt_tag == wsd_pkg::FMT_FLOAT && (bits_per == 32 || bits_per == 64));
    if (!ok) e = wsd_pkg::ERR_FORMAT;
    else if (align == 0) e = wsd_pkg::ERR_ALIGN;
    else if (n_chan == 0) e = wsd_pkg::ERR_NO_CHAN;
    else if (32'(n_chan) * 32'(bits_per >> 3) > 32'(align)) e = wsd_pkg::ERR_OVERRUN;
    else e = wsd_pkg::ERR_NONE;
    if (e != wsd_pkg::ERR_NONE) begin
      pstate = wsd_pkg::PH_IDLE;
      push_item(wsd_pkg::KIND_ERROR, 0, 0, 0, 0, e);
      return;
    end
    frames_left = acc_word / align;
    byte_in_frame = 0;
    chan_idx = 0;
    byte_in_sample = 0;
    sample_word = 0;
    on_last_frame = (frames_left == 1);
    pstate = (frames_left != 0) ? wsd_pkg::PH_DATA : wsd_pkg::PH_IDLE;
    push_item(wsd_pkg::KIND_HEADER, 0, 0, 0, frames_left == 0, wsd_pkg::ERR_NONE);
  endfunction

  function automatic void take_sample_byte(logic [7:0] b);
    logic [31:0] bps;
    logic        fl;
    bps = bits_per >> 3;
    if (32'(byte_in_frame) < 32'(n_chan) * bps) begin
      if (byte_in_sample == 0) sample_word = 0;
      sample_word |= 64'(b) << (8 * byte_in_sample);
      if (32'(byte_in_sample) + 1 >= bps) begin
        fl = (32'(chan_idx) + 1 == 32'(n_chan));
        push_item(wsd_pkg::KIND_SAMPLE, to_f32(sample_word), chan_idx, fl,
                  fl && on_last_frame, wsd_pkg::ERR_NONE);
        chan_idx++;
        byte_in_sample = 0;
      end else begin
        byte_in_sample++;
      end
    end
    byte_in_frame++;
    if (byte_in_frame >= align) begin
      byte_in_frame = 0;
      chan_idx = 0;
      byte_in_sample = 0;
      frames_left--;
      on_last_frame = (frames_left == 1);
      if (frames_left == 0) pstate = wsd_pkg::PH_IDLE;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sof);
    if (sof) clear_parser();
    if (pstate != wsd_pkg::PH_DATA && pstate != wsd_pkg::PH_IDLE &&
        pstate != wsd_pkg::PH_JUNK_SKIP)
      acc_word = {b, acc_word[31:8]};
    case (pstate)
      wsd_pkg::PH_RIFF: begin
        if (hdr_ofs == wsd_pkg::OFS_RIFF_END) begin
          hdr_ofs = 0;
          pstate = (acc_word == wsd_pkg::JUNK_WORD) ? wsd_pkg::PH_JUNK_SIZE
                                                    : wsd_pkg::PH_FMT;
        end else hdr_ofs++;
      end
      wsd_pkg::PH_JUNK_SIZE: begin
        if (hdr_ofs == wsd_pkg::OFS_WORD_END) begin
          hdr_ofs = 0;
          skip_left = acc_word;
          pstate = (skip_left != 0) ? wsd_pkg::PH_JUNK_SKIP : wsd_pkg::PH_JUNK_ID;
        end else hdr_ofs++;
      end
      wsd_pkg::PH_JUNK_SKIP: begin
        skip_left--;
        if (skip_left == 0) pstate = wsd_pkg::PH_JUNK_ID;
      end
      wsd_pkg::PH_JUNK_ID: begin
        if (hdr_ofs == wsd_pkg::OFS_WORD_END) begin
          hdr_ofs = 0;
          pstate = wsd_pkg::PH_FMT;
        end else hdr_ofs++;
      end
      wsd_pkg::PH_FMT: begin
        case (hdr_ofs)
          wsd_pkg::OFS_FORMAT:   fmt_tag = acc_word[31:16];
          wsd_pkg::OFS_CHANNELS: n_chan = acc_word[31:16];
          wsd_pkg::OFS_RATE:     rate = acc_word;
          wsd_pkg::OFS_ALIGN:    align = acc_word[31:16];
          wsd_pkg::OFS_WIDTH:    bits_per = acc_word[31:16];
          default: ;
        endcase
        if (hdr_ofs == wsd_pkg::OFS_FMT_END) begin
          hdr_ofs = 0;
          close_header();
        end else hdr_ofs++;
      end
      wsd_pkg::PH_DATA: take_sample_byte(b);
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    decoded_t d;
    if (rst) begin
      clear_parser();
      decoded_q.delete();
    end else begin
      if (wav.valid && wav.ready) decode_byte(wav.data_byte, wav.start_of_file);
      if (res.valid && res.ready) begin
        if (decoded_q.size() == 0) begin
          report("unexpected beat, kind", res.kind, 0);
        end else begin
          d = decoded_q.pop_front();
          if (res.kind !== d.kind) report("kind", res.kind, d.kind);
          if (res.sample_bits !== d.bits) report("sample_bits", res.sample_bits, d.bits);
          if (res.channel !== d.chan) report("channel", res.channel, d.chan);
          if (res.frame_last !== d.fl) report("frame_last", res.frame_last, d.fl);
          if (res.data_last !== d.dl) report("data_last", res.data_last, d.dl);
          if (res.format_code !== d.fmt) report("format_code", res.format_code, d.fmt);
          if (res.channel_count !== d.nch) report("channel_count", res.channel_count, d.nch);
          if (res.rate_hz !== d.rate) report("rate_hz", res.rate_hz, d.rate);
          if (res.sample_width !== d.width) report("sample_width", res.sample_width, d.width);
          if (res.frame_bytes !== d.align) report("frame_bytes", res.frame_bytes, d.align);
          if (res.error_code !== d.err) report("error_code", res.error_code, d.err);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   quiet;
  int   stall_left;

  logic [7:0]  byte_q[$];
  bit          sof_q[$];
  logic [63:0] sample_script[$];

  wsd_byte_if   wav ();
  wsd_result_if res ();

  wav_stream_sample_decoder u_top (.clk(clk), .rst(rst), .wav(wav), .res(res));

  wsd_checker u_checker (.clk(clk), .rst(rst), .wav(wav), .res(res),
                         .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output stalls come in bursts; the quiet tail of the run has none.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      res.ready <= 1'b0;
      stall_left <= $urandom_range(1, 18);
    end else begin
      res.ready <= 1'b1;
    end
  end

  function automatic void put(logic [63:0] v, int n, bit sof);
    for (int i = 0; i < n; i++) begin
      byte_q.push_back(v[8*i +: 8]);
      sof_q.push_back(sof && i == 0);
    end
  endfunction

  function automatic logic [63:0] pick_f64();
    logic [10:0] e;
    logic [51:0] m;
    m = 52'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: e = 11'($urandom);
      1: e = 0;
      2: begin
        e = 11'h7FF;
        if ($urandom_range(0, 2) == 0) m = 0;
      end
      3: e = 11'($urandom_range(860, 897));
      4: e = 11'($urandom_range(1140, 1160));
      default: begin
        e = 11'($urandom_range(1000, 1100));
        m[28:0] = {1'b1, 28'h0};
      end
    endcase
    return {1'($urandom), e, m};
  endfunction

  function automatic logic [63:0] pick_sample(int w);
    if (sample_script.size() > 0) return sample_script.pop_front();
    if (w == 64) return pick_f64();
    return {$urandom, $urandom};
  endfunction

  // A junk_len below zero means the file has no JUNK chunk.
  function automatic void add_file(int fmt, int nch, logic [31:0] rate_hz, int w, int align,
                                   int junk_len, int frames, int extra, int tail);
    int declared;
    int total;
    int start;
    declared = frames * align + extra;
    total = declared + tail;
    put(32'h46464952, 4, 1'b1);
    put($urandom, 4, 0);
    put(32'h45564157, 4, 0);
    if (junk_len >= 0) begin
      put(wsd_pkg::JUNK_WORD, 4, 0);
      put(junk_len, 4, 0);
      for (int i = 0; i < junk_len; i++) put($urandom, 1, 0);
    end
    put(32'h20746D66, 4, 0);
    put(16, 4, 0);
    put(fmt, 2, 0);
    put(nch, 2, 0);
    put(rate_hz, 4, 0);
    put($urandom, 4, 0);
    put(align, 2, 0);
    put(w, 2, 0);
    put(32'h61746164, 4, 0);
    put(declared, 4, 0);
    start = byte_q.size();
    while (byte_q.size() - start < total) begin
      for (int c = 0; c < nch && 8 * c * (w / 8) < 8 * align; c++) put(pick_sample(w), w / 8, 0);
      for (int p = nch * (w / 8); p < align; p++) put($urandom, 1, 0);
      if (align == 0 || nch * (w / 8) == 0) put($urandom, 1, 0);
    end
    while (byte_q.size() - start > total) begin
      void'(byte_q.pop_back());
      void'(sof_q.pop_back());
    end
  endfunction

  task automatic send_all();
    int gap;
    while (byte_q.size() > 0) begin
      if (!quiet && $urandom_range(0, 11) == 0) begin
        wav.valid <= 1'b0;
        gap = $urandom_range(1, 18);
        repeat (gap) @(posedge clk);
      end
      wav.valid <= 1'b1;
      wav.data_byte <= byte_q.pop_front();
      wav.start_of_file <= sof_q.pop_front();
      do @(posedge clk); while (!wav.ready);
    end
    wav.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_files(int n_bytes);
    int sent;
    int sel;
    int w;
    int nch;
    int align;
    int fmt;
    sent = 0;
    while (sent < n_bytes) begin
      sel = $urandom_range(0, 3);
      fmt = (sel < 2) ? wsd_pkg::FMT_PCM : wsd_pkg::FMT_FLOAT;
      w = (sel == 0) ? 16 : (sel == 1) ? 24 : (sel == 2) ? 32 : 64;
      nch = $urandom_range(1, 3);
      align = nch * (w / 8) + $urandom_range(0, 2);
      case ($urandom_range(0, 11))
        0: fmt = $urandom_range(0, 4);
        1: w = $urandom_range(0, 72);
        2: align = $urandom_range(0, 4);
        3: nch = $urandom_range(0, 4);
        default: ;
      endcase
      add_file(fmt, nch, {$urandom}, w, align,
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1,
               $urandom_range(0, 4), $urandom_range(0, 3),
               ($urandom_range(0, 5) == 0) ? -$urandom_range(1, 6) : $urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0)
        for (int i = $urandom_range(1, 8); i > 0; i--) put($urandom, 1, 0);
      sent += byte_q.size();
      send_all();
    end
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    quiet = 1'b0;
    stall_left = 0;
    wav.valid = 1'b0;
    wav.data_byte = '0;
    wav.start_of_file = 1'b0;
    res.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sample_script = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001};
    add_file(wsd_pkg::FMT_PCM, 2, 32'hFFFFFFFF, 16, 6, -1, 2, 0, 3);
    sample_script = '{24'h800000, 24'h7FFFFF};
    add_file(wsd_pkg::FMT_PCM, 1, 32'h0, 24, 3, 3, 2, 1, 0);
    sample_script = '{64'h3FF0000000000000, 64'h7FF8000000000001, 64'hFFF0000000000000,
                      64'h0000000000000001, 64'h36A0000000000000, 64'h3690000000000000,
                      64'hC7F0000000000000, 64'h3FF0000010000000, 64'h3FF0000030000000};
    add_file(wsd_pkg::FMT_FLOAT, 1, 32'd48000, 64, 8, 0, 9, 0, 0);
    sample_script = '{32'h7F800000, 32'h80000001};
    add_file(wsd_pkg::FMT_FLOAT, 2, 32'd44100, 32, 8, -1, 1, 0, 0);
    add_file(2, 1, 32'd8000, 16, 2, -1, 1, 0, 0);
    add_file(wsd_pkg::FMT_PCM, 1, 32'd8000, 16, 0, -1, 0, 0, 2);
    add_file(wsd_pkg::FMT_PCM, 0, 32'd8000, 16, 2, -1, 1, 0, 0);
    add_file(wsd_pkg::FMT_PCM, 2, 32'd8000, 24, 5, -1, 1, 0, 0);
    add_file(wsd_pkg::FMT_PCM, 1, 32'd8000, 16, 2, -1, 0, 1, 0);
    add_file(wsd_pkg::FMT_PCM, 1, 32'd8000, 16, 2, -1, 3, 0, -4);
    sample_script.delete();
    send_all();

    // Hold the input until the block has drained.
    wait (pending == 0);
    @(posedge clk);

    random_files(750);
    wait (pending == 0);
    quiet = 1'b1;
    random_files(250);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending != 0) $display("%0d expected beats never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
